>>> rtl/point_cloud_to_scan_binning_core_macros.svh
// Assertion macros shared by the scan binning checker.
`ifndef POINT_CLOUD_TO_SCAN_BINNING_CORE_MACROS_SVH
`define POINT_CLOUD_TO_SCAN_BINNING_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PCSB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PCSB_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/pcsb_pkg.sv
// Shared types, codes, widths and the arctangent table of the scan binning core.
`timescale 1ns / 1ps
package pcsb_pkg;

   localparam int MAX_BINS_DEF     = 512;
   localparam int CORDIC_STEPS_DEF = 18;
   localparam int CORDIC_MAX_STEPS = 24;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_HEIGHT = 3'd1,
      ST_RANGE  = 3'd2,
      ST_ANGLE  = 3'd3,
      ST_READ   = 3'd4
   } status_type;

   localparam logic [2:0] REG_MIN_HEIGHT   = 3'd0;
   localparam logic [2:0] REG_MAX_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_RANGE_MIN    = 3'd2;
   localparam logic [2:0] REG_RANGE_MAX    = 3'd3;
   localparam logic [2:0] REG_ANGLE_MIN    = 3'd4;
   localparam logic [2:0] REG_ANGLE_INC    = 3'd5;
   localparam logic [2:0] REG_NUM_BINS     = 3'd6;
   localparam logic [2:0] REG_EMPTY_OFFSET = 3'd7;

   // Arctangent of 2^-i in units of 2^20 per turn.
   function automatic logic [17:0] atan_entry(input logic [4:0] idx);
      logic [17:0] val;
      case (idx)
         5'd0:  val = 18'd131072;
         5'd1:  val = 18'd77376;
         5'd2:  val = 18'd40884;
         5'd3:  val = 18'd20753;
         5'd4:  val = 18'd10417;
         5'd5:  val = 18'd5213;
         5'd6:  val = 18'd2607;
         5'd7:  val = 18'd1304;
         5'd8:  val = 18'd652;
         5'd9:  val = 18'd326;
         5'd10: val = 18'd163;
         5'd11: val = 18'd81;
         5'd12: val = 18'd41;
         5'd13: val = 18'd20;
         5'd14: val = 18'd10;
         5'd15: val = 18'd5;
         5'd16: val = 18'd3;
         5'd17: val = 18'd1;
         5'd18: val = 18'd1;
         default: val = 18'd0;
      endcase
      return val;
   endfunction

endpackage

>>> rtl/pcsb_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle, rounded half up.
`timescale 1ns / 1ps
module pcsb_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [35:0] radicand,
   output logic        busy,
   output logic [17:0] root
);

   logic        busy_ff;
   logic [4:0]  cnt_ff;
   logic [35:0] rad_ff;
   logic [19:0] rem_ff;
   logic [17:0] root_ff;
   logic [17:0] res_ff;

   logic [21:0] rem_sh;
   logic [21:0] trial;
   logic        ge;
   logic [21:0] rem_diff;
   logic [19:0] rem_nx;
   logic [17:0] root_nx;

   always_comb begin
      rem_sh   = {rem_ff, rad_ff[35:34]};
      trial    = {2'b00, root_ff, 2'b01};
      ge       = (rem_sh >= trial);
      rem_diff = rem_sh - trial;
      rem_nx   = ge ? rem_diff[19:0] : rem_sh[19:0];
      root_nx  = {root_ff[16:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[33:0], 2'b00};
         rem_ff  <= rem_nx;
         root_ff <= root_nx;
         cnt_ff  <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd17) begin
            busy_ff <= 1'b0;
            // The remainder is s - r*r; round up when it exceeds r.
            res_ff  <= root_nx + {17'd0, (rem_nx > {2'b00, root_nx})};
         end
      end
   end

   assign busy = busy_ff;
   assign root = res_ff;

endmodule

>>> rtl/pcsb_cordic.sv
// Iterative CORDIC vectoring unit giving the bearing in 65536 units per turn.
`timescale 1ns / 1ps
module pcsb_cordic #(
   parameter int STEPS = pcsb_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [17:0] x_mm,
   input  logic signed [17:0] y_mm,
   output logic               busy,
   output logic signed [15:0] angle
);

   localparam int X_W   = 29;
   localparam int ACC_W = 21;
   localparam int LAST  = ((STEPS < pcsb_pkg::CORDIC_MAX_STEPS) ?
                           STEPS : pcsb_pkg::CORDIC_MAX_STEPS) - 1;

   logic                    busy_ff;
   logic [4:0]              step_ff;
   logic signed [X_W-1:0]   x_ff;
   logic signed [X_W-1:0]   y_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [15:0]      angle_ff;

   logic signed [X_W-1:0]   x_s;
   logic signed [X_W-1:0]   y_s;
   logic signed [X_W-1:0]   xs;
   logic signed [X_W-1:0]   ys;
   logic signed [ACC_W-1:0] tab;
   logic                    rot_neg;
   logic signed [X_W-1:0]   x_nx;
   logic signed [X_W-1:0]   y_nx;
   logic signed [ACC_W-1:0] acc_nx;
   logic signed [ACC_W-1:0] acc_rnd;

   always_comb begin
      x_s     = {{(X_W-26){x_mm[17]}}, x_mm, 8'b0};
      y_s     = {{(X_W-26){y_mm[17]}}, y_mm, 8'b0};
      xs      = x_ff >>> step_ff;
      ys      = y_ff >>> step_ff;
      tab     = {{(ACC_W-18){1'b0}}, pcsb_pkg::atan_entry(step_ff)};
      rot_neg = y_ff[X_W-1];
      x_nx    = rot_neg ? (x_ff - ys) : (x_ff + ys);
      y_nx    = rot_neg ? (y_ff + xs) : (y_ff - xs);
      acc_nx  = rot_neg ? (acc_ff - tab) : (acc_ff + tab);
      acc_rnd = acc_nx + ACC_W'(8);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         step_ff <= '0;
         if (x_mm == '0 && y_mm == '0) begin
            angle_ff <= '0;
         end else begin
            busy_ff <= 1'b1;
            // Points left of the y axis are first turned a quarter turn.
            if (x_mm[17]) begin
               if (!y_mm[17]) begin
                  x_ff   <= y_s;
                  y_ff   <= -x_s;
                  acc_ff <= ACC_W'(262144);
               end else begin
                  x_ff   <= -y_s;
                  y_ff   <= x_s;
                  acc_ff <= -ACC_W'(262144);
               end
            end else begin
               x_ff   <= x_s;
               y_ff   <= y_s;
               acc_ff <= '0;
            end
         end
      end else if (busy_ff) begin
         x_ff    <= x_nx;
         y_ff    <= y_nx;
         acc_ff  <= acc_nx;
         step_ff <= step_ff + 5'd1;
         if (step_ff == 5'(LAST)) begin
            busy_ff  <= 1'b0;
            angle_ff <= acc_rnd[19:4];
         end
      end
   end

   assign busy  = busy_ff;
   assign angle = angle_ff;

endmodule

>>> rtl/pcsb_div.sv
// Bit-serial restoring divider for the bin index, one quotient bit per cycle.
`timescale 1ns / 1ps
module pcsb_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [17:0] dividend,
   input  logic [16:0] divisor,
   output logic        busy,
   output logic [17:0] quotient
);

   logic        busy_ff;
   logic [4:0]  cnt_ff;
   logic [17:0] dvd_ff;
   logic [16:0] dvs_ff;
   logic [16:0] rem_ff;

   logic [17:0] rem_sh;
   logic [17:0] rem_diff;
   logic        ge;

   always_comb begin
      rem_sh   = {rem_ff, dvd_ff[17]};
      ge       = (rem_sh >= {1'b0, dvs_ff});
      rem_diff = rem_sh - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         dvd_ff  <= dividend;
         dvs_ff  <= divisor;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         // Quotient bits shift in where the dividend bits shift out.
         dvd_ff <= {dvd_ff[16:0], ge};
         rem_ff <= ge ? rem_diff[16:0] : rem_sh[16:0];
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'd17) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff;

endmodule

>>> rtl/point_cloud_to_scan_binning_core.sv
// Top level of the scan binning core: sequencer, configuration and bin memory.
`timescale 1ns / 1ps
// Flattens 3D points into a 2D range scan held in a MAX_BINS-entry bin memory.
// Items are processed one at a time. An add-point transaction squares x and y
// on one shared 18x18 multiplier, then runs the two-bit-per-cycle square root
// alongside the CORDIC unit and, for a non-negative angle offset, the
// one-bit-per-cycle bin divider. A read goes through the registered memory
// read. A clear sweeps the bin memory one entry per cycle; the same sweep runs
// after reset, during which no request is accepted. Configuration writes are
// taken at any time but must only be issued while the core is idle.
module point_cloud_to_scan_binning_core #(
   parameter int MAX_BINS     = pcsb_pkg::MAX_BINS_DEF,
   parameter int CORDIC_STEPS = pcsb_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic signed [17:0] req_x_mm,
   input  logic signed [17:0] req_y_mm,
   input  logic signed [17:0] req_z_mm,
   input  logic [8:0]         req_read_bin,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [8:0]         rsp_bin_number,
   output logic [17:0]        rsp_range_mm,
   output logic               rsp_bin_empty,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [17:0]        csr_data
);

   localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int MEM_W  = 19;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_SQX, S_SQY, S_START, S_CALC,
      S_RCHK, S_DIV, S_BIN, S_WAIT, S_USE, S_RESP
   } state_type;

   // Configuration registers.
   logic signed [17:0] min_height_ff;
   logic signed [17:0] max_height_ff;
   logic [17:0]        range_min_ff;
   logic [17:0]        range_max_ff;
   logic signed [15:0] angle_min_ff;
   logic [15:0]        angle_inc_ff;
   logic [9:0]         num_bins_ff;
   logic [15:0]        empty_offset_ff;

   state_type              state_ff;
   pcsb_pkg::cmd_type      cmd_ff;
   logic signed [17:0]     x_ff;
   logic signed [17:0]     y_ff;
   logic signed [17:0]     z_ff;
   logic [8:0]             rb_ff;
   logic [35:0]            sq_ff;
   logic [17:0]            rng_ff;
   logic [17:0]            idx_ff;
   logic [ADDR_W-1:0]      addr_ff;
   logic [ADDR_W-1:0]      clr_addr_ff;
   logic                   clr_rsp_ff;
   pcsb_pkg::status_type   res_status_ff;
   logic [8:0]             res_bin_ff;
   logic [17:0]            res_rng_ff;
   logic                   res_empty_ff;
   logic                   rsp_valid_ff;
   logic [2:0]             rsp_status_ff;
   logic [8:0]             rsp_bin_ff;
   logic [17:0]            rsp_rng_ff;
   logic                   rsp_empty_ff;

   logic [MEM_W-1:0] bin_mem [MAX_BINS];
   logic [MEM_W-1:0] rd_data_ff;
   logic             mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [MEM_W-1:0] mem_wd;

   logic signed [17:0] mul_op;
   logic signed [35:0] mul_res;
   logic [17:0]        used;
   logic [17:0]        rb_ext;
   logic signed [16:0] diff;
   logic [15:0]        inc_eff;
   logic [16:0]        two_inc;
   logic signed [18:0] n_val;
   logic signed [18:0] n_mag;
   logic [18:0]        empty_sum;
   logic [17:0]        empty_rng;
   logic               upd;
   logic               sqrt_busy;
   logic [17:0]        sqrt_root;
   logic               cordic_busy;
   logic signed [15:0] bearing;
   logic               div_start;
   logic               div_busy;
   logic [17:0]        div_quot;
   logic               calc_start;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_height_ff   <= -18'sd500;
         max_height_ff   <= 18'sd500;
         range_min_ff    <= 18'd100;
         range_max_ff    <= 18'd50000;
         angle_min_ff    <= 16'sh8000;
         angle_inc_ff    <= 16'd182;
         num_bins_ff     <= 10'd360;
         empty_offset_ff <= 16'd1000;
      end else if (csr_valid) begin
         unique case (csr_index)
            pcsb_pkg::REG_MIN_HEIGHT:   min_height_ff   <= csr_data;
            pcsb_pkg::REG_MAX_HEIGHT:   max_height_ff   <= csr_data;
            pcsb_pkg::REG_RANGE_MIN:    range_min_ff    <= csr_data;
            pcsb_pkg::REG_RANGE_MAX:    range_max_ff    <= csr_data;
            pcsb_pkg::REG_ANGLE_MIN:    angle_min_ff    <= csr_data[15:0];
            pcsb_pkg::REG_ANGLE_INC:    angle_inc_ff    <= csr_data[15:0];
            pcsb_pkg::REG_NUM_BINS:     num_bins_ff     <= csr_data[9:0];
            pcsb_pkg::REG_EMPTY_OFFSET: empty_offset_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      mul_op    = (state_ff == S_SQX) ? x_ff : y_ff;
      mul_res   = mul_op * mul_op;
      used      = ({8'd0, num_bins_ff} < 18'(MAX_BINS)) ? {8'd0, num_bins_ff}
                                                        : 18'(MAX_BINS);
      rb_ext    = {9'd0, rb_ff};
      diff      = {bearing[15], bearing} - {angle_min_ff[15], angle_min_ff};
      inc_eff   = (angle_inc_ff == '0) ? 16'd1 : angle_inc_ff;
      two_inc   = {inc_eff, 1'b0};
      n_val     = {{1{diff[16]}}, diff, 1'b0} + {3'd0, inc_eff};
      n_mag     = -n_val;
      empty_sum = {1'b0, range_max_ff} + {3'd0, empty_offset_ff};
      empty_rng = empty_sum[18] ? 18'h3FFFF : empty_sum[17:0];
      upd       = !rd_data_ff[18] || (rng_ff < rd_data_ff[17:0]);
      calc_start = (state_ff == S_START);
      div_start = (state_ff == S_RCHK) && !n_val[18] &&
                  !(sqrt_root < range_min_ff || sqrt_root > range_max_ff);
      mem_we    = (state_ff == S_CLEAR) ||
                  (state_ff == S_USE && cmd_ff == pcsb_pkg::CMD_ADD && upd);
      mem_wa    = (state_ff == S_CLEAR) ? clr_addr_ff : addr_ff;
      mem_wd    = (state_ff == S_CLEAR) ? '0 : {1'b1, rng_ff};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= bin_mem[addr_ff];
   end

   pcsb_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (calc_start),
      .radicand (sq_ff),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   pcsb_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (calc_start),
      .x_mm  (x_ff),
      .y_mm  (y_ff),
      .busy  (cordic_busy),
      .angle (bearing)
   );

   pcsb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (n_val[17:0]),
      .divisor  (two_inc),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_RESP && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= res_status_ff;
            rsp_bin_ff    <= res_bin_ff;
            rsp_rng_ff    <= res_rng_ff;
            rsp_empty_ff  <= res_empty_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_CLEAR: begin
               if (clr_addr_ff == ADDR_W'(MAX_BINS - 1)) begin
                  clr_addr_ff <= '0;
                  state_ff    <= clr_rsp_ff ? S_RESP : S_IDLE;
               end else begin
                  clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= pcsb_pkg::cmd_type'(req_cmd);
                  x_ff     <= req_x_mm;
                  y_ff     <= req_y_mm;
                  z_ff     <= req_z_mm;
                  rb_ff    <= req_read_bin;
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               res_rng_ff   <= '0;
               res_empty_ff <= 1'b0;
               unique case (cmd_ff)
                  pcsb_pkg::CMD_CLEAR: begin
                     res_status_ff <= pcsb_pkg::ST_OK;
                     res_bin_ff    <= '0;
                     clr_addr_ff   <= '0;
                     clr_rsp_ff    <= 1'b1;
                     state_ff      <= S_CLEAR;
                  end
                  pcsb_pkg::CMD_ADD: begin
                     res_bin_ff <= '0;
                     if (z_ff < min_height_ff || z_ff > max_height_ff) begin
                        res_status_ff <= pcsb_pkg::ST_HEIGHT;
                        state_ff      <= S_RESP;
                     end else begin
                        res_status_ff <= pcsb_pkg::ST_OK;
                        state_ff      <= S_SQX;
                     end
                  end
                  pcsb_pkg::CMD_READ: begin
                     res_bin_ff <= rb_ff;
                     if (rb_ext >= used) begin
                        res_status_ff <= pcsb_pkg::ST_READ;
                        state_ff      <= S_RESP;
                     end else begin
                        res_status_ff <= pcsb_pkg::ST_OK;
                        addr_ff       <= rb_ext[ADDR_W-1:0];
                        state_ff      <= S_WAIT;
                     end
                  end
                  default: begin
                     res_status_ff <= pcsb_pkg::ST_OK;
                     res_bin_ff    <= '0;
                     state_ff      <= S_RESP;
                  end
               endcase
            end
            S_SQX: begin
               sq_ff    <= unsigned'(mul_res);
               state_ff <= S_SQY;
            end
            S_SQY: begin
               sq_ff    <= sq_ff + unsigned'(mul_res);
               state_ff <= S_START;
            end
            S_START: state_ff <= S_CALC;
            S_CALC: begin
               if (!sqrt_busy && !cordic_busy) begin
                  state_ff <= S_RCHK;
               end
            end
            S_RCHK: begin
               rng_ff     <= sqrt_root;
               res_rng_ff <= sqrt_root;
               if (sqrt_root < range_min_ff || sqrt_root > range_max_ff) begin
                  res_status_ff <= pcsb_pkg::ST_RANGE;
                  state_ff      <= S_RESP;
               end else if (!n_val[18]) begin
                  state_ff <= S_DIV;
               end else if (n_mag < {2'b00, two_inc}) begin
                  // A small negative offset still truncates into bin zero.
                  idx_ff   <= '0;
                  state_ff <= S_BIN;
               end else begin
                  res_status_ff <= pcsb_pkg::ST_ANGLE;
                  state_ff      <= S_RESP;
               end
            end
            S_DIV: begin
               if (!div_busy) begin
                  idx_ff   <= div_quot;
                  state_ff <= S_BIN;
               end
            end
            S_BIN: begin
               if (idx_ff >= used) begin
                  res_status_ff <= pcsb_pkg::ST_ANGLE;
                  state_ff      <= S_RESP;
               end else begin
                  addr_ff  <= idx_ff[ADDR_W-1:0];
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: state_ff <= S_USE;
            S_USE: begin
               if (cmd_ff == pcsb_pkg::CMD_ADD) begin
                  res_bin_ff <= idx_ff[8:0];
               end else if (rd_data_ff[18]) begin
                  res_rng_ff <= rd_data_ff[17:0];
               end else begin
                  res_rng_ff   <= empty_rng;
                  res_empty_ff <= 1'b1;
               end
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  clr_rsp_ff <= 1'b0;
                  state_ff   <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_bin_number = rsp_bin_ff;
   assign rsp_range_mm   = rsp_rng_ff;
   assign rsp_bin_empty  = rsp_empty_ff;

endmodule

>>> rtl/pcsb_checker.sv
// Port-level checker for the scan binning core and its bind statement.
`timescale 1ns / 1ps
`include "point_cloud_to_scan_binning_core_macros.svh"
module pcsb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [8:0]  rsp_bin_number,
   input logic [17:0] rsp_range_mm,
   input logic        rsp_bin_empty
);

   // A stalled result transaction must keep its payload.
   `PCSB_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_bin_number) && $stable(rsp_range_mm), "result changed while stalled")

   `PCSB_ASSERT_IMP(a_status_code, rsp_valid, rsp_status == 3'(pcsb_pkg::ST_OK) || rsp_status == 3'(pcsb_pkg::ST_HEIGHT) || rsp_status == 3'(pcsb_pkg::ST_RANGE) || rsp_status == 3'(pcsb_pkg::ST_ANGLE) || rsp_status == 3'(pcsb_pkg::ST_READ), "undefined status code")

   // Only a successful read can report an empty bin.
   `PCSB_ASSERT_IMP(a_empty_ok, rsp_valid && rsp_bin_empty, rsp_status == 3'(pcsb_pkg::ST_OK), "empty flag on a failed transaction")

   // Height and read rejects carry no range.
   `PCSB_ASSERT_IMP(a_reject_zero, rsp_valid && (rsp_status == 3'(pcsb_pkg::ST_HEIGHT) || rsp_status == 3'(pcsb_pkg::ST_READ)), rsp_range_mm == 18'd0 && !rsp_bin_empty, "reject carries a range")

endmodule

bind point_cloud_to_scan_binning_core pcsb_checker u_pcsb_checker (.*);

>>> sim/scan_binning_checker.sv
// Checker for the scan binning core: predicts every response and compares it.
`timescale 1ns / 1ps
module scan_binning_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic signed [17:0] req_x_mm,
   input  logic signed [17:0] req_y_mm,
   input  logic signed [17:0] req_z_mm,
   input  logic [8:0]         req_read_bin,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_status,
   input  logic [8:0]         rsp_bin_number,
   input  logic [17:0]        rsp_range_mm,
   input  logic               rsp_bin_empty,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [17:0]        csr_data,
   output int                 errors,
   output int                 pending
);

   localparam int NBINS = pcsb_pkg::MAX_BINS_DEF;

   typedef struct packed {
      logic [2:0]  status;
      logic [8:0]  bin;
      logic [17:0] range_mm;
      logic        empty;
   } scan_result_type;

   scan_result_type expected_q[$];

   logic signed [17:0] min_h, max_h;
   logic [17:0]        range_lo, range_hi;
   logic signed [15:0] angle_base;
   logic [15:0]        angle_step;
   logic [9:0]         bins_cfg;
   logic [15:0]        empty_add;
   logic               bin_full[NBINS];
   logic [17:0]        bin_nearest[NBINS];

   function automatic longint unsigned rounded_root(longint unsigned s);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 19; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= s) r = t;
      end
      if (s - r * r > r) r++;
      return r;
   endfunction

   function automatic longint point_bearing(longint x, longint y);
      longint acc, t, xs, ys;
      logic signed [15:0] wrapped;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; acc = 262144;
         end else begin
            t = x; x = -y; y = t; acc = -262144;
         end
      end
      for (int i = 0; i < pcsb_pkg::CORDIC_STEPS_DEF && i < pcsb_pkg::CORDIC_MAX_STEPS;
           i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; acc += longint'(pcsb_pkg::atan_entry(5'(i)));
         end else begin
            x = x - ys; y = y + xs; acc -= longint'(pcsb_pkg::atan_entry(5'(i)));
         end
      end
      acc = (acc + 8) >>> 4;
      wrapped = acc[15:0];
      return longint'(wrapped);
   endfunction

   task automatic predict_scan(output scan_result_type res);
      longint x, y, z, inc, n, idx, used;
      longint unsigned rng;
      logic ok;
      res = '0;
      used = (bins_cfg < NBINS) ? longint'(bins_cfg) : longint'(NBINS);
      case (pcsb_pkg::cmd_type'(req_cmd))
         pcsb_pkg::CMD_CLEAR: begin
            for (int i = 0; i < NBINS; i++) bin_full[i] = 1'b0;
         end
         pcsb_pkg::CMD_ADD: begin
            x = longint'(req_x_mm);
            y = longint'(req_y_mm);
            z = longint'(req_z_mm);
            if (z < min_h || z > max_h) begin
               res.status = pcsb_pkg::ST_HEIGHT;
            end else begin
               rng = rounded_root(longint'(x * x + y * y));
               res.range_mm = rng[17:0];
               if (rng < range_lo || rng > range_hi) begin
                  res.status = pcsb_pkg::ST_RANGE;
               end else begin
                  inc = (angle_step == 0) ? 1 : longint'(angle_step);
                  n = 2 * (point_bearing(x, y) - angle_base) + inc;
                  ok = 1'b1;
                  idx = 0;
                  if (n >= 0) idx = n / (2 * inc);
                  else if (-n >= 2 * inc) ok = 1'b0;
                  if (!ok || idx >= used) begin
                     res.status = pcsb_pkg::ST_ANGLE;
                  end else begin
                     res.bin = idx[8:0];
                     if (!bin_full[idx] || rng < bin_nearest[idx]) begin
                        bin_nearest[idx] = rng[17:0];
                        bin_full[idx] = 1'b1;
                     end
                  end
               end
            end
         end
         pcsb_pkg::CMD_READ: begin
            res.bin = req_read_bin;
            if (req_read_bin >= used) begin
               res.status = pcsb_pkg::ST_READ;
            end else if (bin_full[req_read_bin]) begin
               res.range_mm = bin_nearest[req_read_bin];
            end else begin
               rng = longint'(range_hi) + longint'(empty_add);
               res.range_mm = (rng > 262143) ? 18'h3FFFF : rng[17:0];
               res.empty = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      scan_result_type want, got;
      if (reset) begin
         min_h = -18'sd500;
         max_h = 18'sd500;
         range_lo = 18'd100;
         range_hi = 18'd50000;
         angle_base = 16'sh8000;
         angle_step = 16'd182;
         bins_cfg = 10'd360;
         empty_add = 16'd1000;
         for (int i = 0; i < NBINS; i++) bin_full[i] = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pcsb_pkg::REG_MIN_HEIGHT:   min_h = csr_data;
               pcsb_pkg::REG_MAX_HEIGHT:   max_h = csr_data;
               pcsb_pkg::REG_RANGE_MIN:    range_lo = csr_data;
               pcsb_pkg::REG_RANGE_MAX:    range_hi = csr_data;
               pcsb_pkg::REG_ANGLE_MIN:    angle_base = csr_data[15:0];
               pcsb_pkg::REG_ANGLE_INC:    angle_step = csr_data[15:0];
               pcsb_pkg::REG_NUM_BINS:     bins_cfg = csr_data[9:0];
               pcsb_pkg::REG_EMPTY_OFFSET: empty_add = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predict_scan(want);
            expected_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_status, rsp_bin_number, rsp_range_mm, rsp_bin_empty};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response status=%0d bin=%0d range=%0d empty=%0d",
                        $time, got.status, got.bin, got.range_mm, got.empty);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (got != want) begin
                  $display("%0t: mismatch expected status=%0d bin=%0d range=%0d empty=%0d",
                           $time, want.status, want.bin, want.range_mm, want.empty);
                  $display("%0t:            actual status=%0d bin=%0d range=%0d empty=%0d",
                           $time, got.status, got.bin, got.range_mm, got.empty);
                  errors++;
               end
            end
         end
      end
      pending = expected_q.size();
   end

endmodule

>>> sim/tb_point_cloud_to_scan_binning_core.sv
// Top of the scan binning testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_point_cloud_to_scan_binning_core;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_cmd;
   logic signed [17:0] req_x_mm, req_y_mm, req_z_mm;
   logic [8:0]         req_read_bin;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [2:0]         rsp_status;
   logic [8:0]         rsp_bin_number;
   logic [17:0]        rsp_range_mm;
   logic               rsp_bin_empty;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [17:0]        csr_data;
   int                 errors, pending;

   int src_idle_pct, sink_idle_pct;
   int hold_left;
   logic hold_req;
   int points_sent;
   int z_lo, z_hi;

   point_cloud_to_scan_binning_core dut (.*);

   scan_binning_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // The receiver side: random back-pressure, plus a long hold-off on request.
   initial begin
      rsp_ready = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_left = 400;
            hold_req = 0;
         end
         if (hold_left > 0) begin
            rsp_ready = 0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   task automatic set_idling();
      if (points_sent < 633) begin
         src_idle_pct = 8;
         sink_idle_pct = 69;
      end else if (points_sent < 1266) begin
         src_idle_pct = 69;
         sink_idle_pct = 8;
      end else begin
         src_idle_pct = 0;
         sink_idle_pct = 0;
      end
   endtask

   task automatic send_item(pcsb_pkg::cmd_type c, int x, int y, int z, int b);
      set_idling();
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_cmd = c;
      req_x_mm = 18'(x);
      req_y_mm = 18'(y);
      req_z_mm = 18'(z);
      req_read_bin = 9'(b);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      points_sent++;
   endtask

   task automatic drain();
      req_valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, int value);
      csr_valid = 1;
      csr_index = idx;
      csr_data = 18'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic load_config(int mn, int mx, int rlo, int rhi, int amin, int ainc,
                              int nb, int eo);
      drain();
      write_reg(pcsb_pkg::REG_MIN_HEIGHT, mn);
      write_reg(pcsb_pkg::REG_MAX_HEIGHT, mx);
      write_reg(pcsb_pkg::REG_RANGE_MIN, rlo);
      write_reg(pcsb_pkg::REG_RANGE_MAX, rhi);
      write_reg(pcsb_pkg::REG_ANGLE_MIN, amin);
      write_reg(pcsb_pkg::REG_ANGLE_INC, ainc);
      write_reg(pcsb_pkg::REG_NUM_BINS, nb);
      write_reg(pcsb_pkg::REG_EMPTY_OFFSET, eo);
      z_lo = mn;
      z_hi = mx;
   endtask

   function automatic int rand_coord();
      int m;
      m = 1 << $urandom_range(17, 4);
      if ($urandom_range(9) == 0) return $signed(18'($urandom()));
      return int'($urandom_range(2 * m)) - m;
   endfunction

   task automatic send_random();
      int pick, z;
      pick = $urandom_range(99);
      if (z_lo <= z_hi && $urandom_range(9) < 8)
         z = z_lo + int'($urandom_range(z_hi - z_lo));
      else
         z = $signed(18'($urandom()));
      if (pick < 3)
         send_item(pcsb_pkg::CMD_CLEAR, rand_coord(), rand_coord(), z, $urandom_range(511));
      else if (pick < 5)
         send_item(pcsb_pkg::CMD_NONE, rand_coord(), rand_coord(), z, $urandom_range(511));
      else if (pick < 22)
         send_item(pcsb_pkg::CMD_READ, rand_coord(), rand_coord(), z, $urandom_range(511));
      else
         send_item(pcsb_pkg::CMD_ADD, rand_coord(), rand_coord(), z, $urandom_range(511));
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2 && points_sent < 633) hold_req = 1;
         if (i == count / 3) drain();
         send_random();
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_cmd = pcsb_pkg::CMD_NONE;
      req_x_mm = 0;
      req_y_mm = 0;
      req_z_mm = 0;
      req_read_bin = 0;
      csr_valid = 0;
      csr_index = pcsb_pkg::REG_MIN_HEIGHT;
      csr_data = 0;
      hold_req = 0;
      points_sent = 0;
      z_lo = -500;
      z_hi = 500;
      src_idle_pct = 8;
      sink_idle_pct = 69;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // The bin memory is swept after reset; wait until requests are taken.
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);

      // Directed items under the reset configuration.
      send_item(pcsb_pkg::CMD_CLEAR, 0, 0, 0, 0);
      send_item(pcsb_pkg::CMD_ADD, 1000, 0, 0, 0);
      send_item(pcsb_pkg::CMD_ADD, 800, 1, 500, 0);
      send_item(pcsb_pkg::CMD_ADD, 0, 0, 0, 0);
      send_item(pcsb_pkg::CMD_ADD, 50, 0, 0, 0);
      send_item(pcsb_pkg::CMD_ADD, 131071, 131071, 0, 0);
      send_item(pcsb_pkg::CMD_ADD, -131072, -131072, -131072, 511);
      send_item(pcsb_pkg::CMD_ADD, 100, 100, 131071, 0);
      send_item(pcsb_pkg::CMD_ADD, 300, 200, -500, 0);
      send_item(pcsb_pkg::CMD_ADD, 300, 200, 501, 0);
      send_item(pcsb_pkg::CMD_ADD, -1000, 1, 0, 0);
      send_item(pcsb_pkg::CMD_ADD, -1000, -1, 0, 0);
      send_item(pcsb_pkg::CMD_ADD, -1000, 0, 0, 0);
      send_item(pcsb_pkg::CMD_ADD, 0, -2000, 0, 0);
      send_item(pcsb_pkg::CMD_ADD, -700, 700, 0, 0);
      send_item(pcsb_pkg::CMD_ADD, 30000, 30000, 0, 0);
      send_item(pcsb_pkg::CMD_READ, 0, 0, 0, 180);
      send_item(pcsb_pkg::CMD_READ, 0, 0, 0, 359);
      send_item(pcsb_pkg::CMD_READ, 0, 0, 0, 360);
      send_item(pcsb_pkg::CMD_READ, 0, 0, 0, 511);
      send_item(pcsb_pkg::CMD_NONE, -1, -1, -1, 511);
      send_item(pcsb_pkg::CMD_READ, 0, 0, 0, 0);
      send_item(pcsb_pkg::CMD_CLEAR, 0, 0, 0, 0);
      send_item(pcsb_pkg::CMD_READ, 0, 0, 0, 180);
      random_phase(360);

      load_config(-131072, 131071, 0, 185364, -32768, 128, 512, 65535);
      random_phase(420);
      // An inverted height window rejects every point.
      load_config(200, -200, 185364, 0, 0, 65535, 512, 0);
      random_phase(80);
      // Empty bins read as the saturated maximum here.
      load_config(-1000, 1000, 0, 262143, 32767, 65535, 1, 65535);
      random_phase(300);
      // A zero increment acts as one, and num_bins above the memory size is clamped.
      load_config(-2000, 3000, 50, 20000, -16384, 0, 1023, 0);
      random_phase(300);
      load_config(-int'($urandom_range(3000)), int'($urandom_range(3000)),
                  $urandom_range(500), 1000 + $urandom_range(100000),
                  int'($urandom_range(65535)) - 32768, 1 + $urandom_range(1000),
                  1 + $urandom_range(511), $urandom_range(65535));
      random_phase(440);

      req_valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/pcsb_pkg.sv
rtl/pcsb_sqrt.sv
rtl/pcsb_cordic.sv
rtl/pcsb_div.sv
rtl/point_cloud_to_scan_binning_core.sv
rtl/pcsb_checker.sv
sim/scan_binning_checker.sv
sim/tb_point_cloud_to_scan_binning_core.sv
